// File: rtl/core/kmer2b_pkg.sv
// Shared constants, types and the base-code function of the k-mer packer.
// No dependencies; every module of the block imports this package.
package kmer2b_pkg;

  localparam int CODE_W    = 2;
  localparam int NUM_CELLS = 32;
  localparam int WORD_W    = CODE_W * NUM_CELLS;
  localparam int KLEN_W    = 6;
  localparam int SHIFT_W   = 5;
  localparam int CHAR_W    = 8;

  localparam logic [KLEN_W-1:0] MAX_KMER_LEN   = KLEN_W'(NUM_CELLS);
  localparam logic [KLEN_W-1:0] KMER_LEN_RESET = KLEN_W'(21);
  localparam logic [KLEN_W-1:0] COUNT_MAX      = '1;

  localparam logic [CHAR_W-1:0] CHAR_SEP = 8'h5F;  // '_'
  localparam logic [CHAR_W-1:0] CHAR_UNK = 8'h4E;  // 'N'

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctl_t;

  // A=0, C=1, G=2, T=3 from bits 2 and 1 of the character.
  function automatic code_t base_code(input logic [CHAR_W-1:0] c);
    logic [CODE_W-1:0] x;
    logic [CODE_W-1:0] y;
    x = {c[2], 1'b0};
    y = (x ^ {c[1], 1'b0}) >> 1;
    return x + y;
  endfunction

endpackage

// File: rtl/core/kmer2b_cell.sv
// One window cell: holds the 2-bit code of one base position.
// Depends on kmer2b_pkg.
module kmer2b_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  kmer2b_pkg::cell_ctl_t ctl,
  input  kmer2b_pkg::code_t     code_in,
  output kmer2b_pkg::code_t     code
);
  import kmer2b_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || (ctl.advance && ctl.clear)) begin
      code <= '0;
    end else if (ctl.advance) begin
      code <= code_in;
    end
  end

endmodule

// File: rtl/core/kmer2b_align.sv
// Left-aligns the k newest bases of the window so the oldest lands in the top bits.
// Depends on kmer2b_pkg.
module kmer2b_align (
  input  logic [kmer2b_pkg::WORD_W-1:0]  window,
  input  logic [kmer2b_pkg::SHIFT_W-1:0] shift_bases,
  output logic [kmer2b_pkg::WORD_W-1:0]  word
);
  import kmer2b_pkg::*;

  logic [WORD_W-1:0] stage [0:SHIFT_W];

  // log shifter, one level per bit of the base count
  always_comb begin
    stage[0] = window;
    for (int l = 0; l < SHIFT_W; l++) begin
      stage[l+1] = shift_bases[l] ? (stage[l] << (CODE_W * (1 << l))) : stage[l];
    end
    word = stage[SHIFT_W];
  end

endmodule

// File: rtl/core/kmer_two_bit_packer_unit.sv
// Top level of the k-mer two-bit packer: cell chain, counters, output register.
// Depends on kmer2b_pkg, kmer2b_cell and kmer2b_align.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one character beat: base_char
//   and last_of_block. Output channel (out_valid / out_stall) carries one
//   k-mer beat: kmer_word, left-aligned with the first base in bits 63:62,
//   and kmer_valid, clear (word zero) when the k-mer spans '_' or 'N'.
//   A beat produces output only once k characters of the block have arrived.
//   cfg_we / cfg_wdata write kmer_length (k); 0 acts as 1, above 32 as 32.
//   Write it only while the block is idle.
// Timing:
//   One character per cycle while no stall holds the output. Result appears in
//   the cycle after its input beat, from the output register; the path is set
//   by the 5-level aligning shifter feeding that register.
// Reset (rst, synchronous): clears the window, both counts and out_valid
//   of the output register; kmer_length returns to 21.
// Stall: while out_stall holds a waiting result, in_stall rises and the
//   chain holds; a free or draining output register takes a new beat at once.
module kmer_two_bit_packer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kmer2b_pkg::KLEN_W-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kmer2b_pkg::CHAR_W-1:0]   base_char,
  input  logic                            last_of_block,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kmer2b_pkg::WORD_W-1:0]   kmer_word,
  output logic                            kmer_valid
);
  import kmer2b_pkg::*;

  logic [KLEN_W-1:0] kmer_length;
  logic [KLEN_W-1:0] fill_count;
  logic [KLEN_W-1:0] fill_count_next;
  logic [KLEN_W-1:0] clean_run;
  logic [KLEN_W-1:0] clean_run_next;
  logic [KLEN_W-1:0] k_eff;
  logic [KLEN_W-1:0] shift_full;
  logic              accept;
  logic              bad_char;
  logic              emit;
  logic              good;
  cell_ctl_t         ctl;
  code_t             cell_code [NUM_CELLS];
  logic [WORD_W-1:0] window_shift;
  logic [WORD_W-1:0] aligned;

  // Take a beat whenever the output register is empty or being drained.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign bad_char = (base_char == CHAR_SEP) || (base_char == CHAR_UNK);

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KMER_LEN_RESET;
    end else if (cfg_we) begin
      kmer_length <= cfg_wdata;
    end
  end

  // Clamp k into 1..32.
  always_comb begin
    k_eff = kmer_length;
    if (k_eff == '0) begin
      k_eff = KLEN_W'(1);
    end
    if (k_eff > MAX_KMER_LEN) begin
      k_eff = MAX_KMER_LEN;
    end
    shift_full = MAX_KMER_LEN - k_eff;
  end

  // Counts as they stand after this beat, before any end-of-block clear.
  always_comb begin
    fill_count_next = (fill_count < COUNT_MAX) ? fill_count + 1'b1 : fill_count;
    if (bad_char) begin
      clean_run_next = '0;
    end else begin
      clean_run_next = (clean_run < COUNT_MAX) ? clean_run + 1'b1 : clean_run;
    end
    emit = fill_count_next >= k_eff;
    good = clean_run_next >= k_eff;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_of_block)) begin
      fill_count <= '0;
      clean_run  <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      clean_run  <= clean_run_next;
    end
  end

  // Chain of cells: cell 0 holds the newest base, each hands its code on.
  assign ctl.advance = accept;
  assign ctl.clear   = last_of_block;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    code_t code_in;
    if (i == 0) begin : g_head
      assign code_in = base_code(base_char);
    end else begin : g_link
      assign code_in = cell_code[i-1];
    end
    kmer2b_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .code_in (code_in),
      .code    (cell_code[i])
    );
    // window after shifting in this beat
    assign window_shift[CODE_W*i +: CODE_W] = code_in;
  end

  kmer2b_align u_align (
    .window      (window_shift),
    .shift_bases (shift_full[SHIFT_W-1:0]),
    .word        (aligned)
  );

  // Output register: load on an emitting beat, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kmer_word  <= good ? aligned : '0;
      kmer_valid <= good;
    end
  end

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kmer_valid) |-> (kmer_word == '0))
    else $error("invalid k-mer carries a nonzero word");

  a_block_clear : assert property (@(posedge clk) disable iff (rst)
    (accept && last_of_block) |=> (fill_count == '0 && clean_run == '0))
    else $error("counts not cleared after end of block");

  a_run_le_fill : assert property (@(posedge clk) disable iff (rst)
    clean_run <= fill_count)
    else $error("clean run exceeds fill count");

  a_bad_resets_run : assert property (@(posedge clk) disable iff (rst)
    (accept && bad_char) |=> (clean_run == '0))
    else $error("separator or unknown base did not reset the clean run");

endmodule
